@@ design/rsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and character helpers for the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int VALUE_BITS_DEF  = 32;
  localparam int DIGIT_SLOTS_DEF = 32;

  localparam int CHAR_BITS  = 8;
  localparam int BASE_BITS  = 6;
  localparam int DIGIT_BITS = 6;
  localparam int INDEX_BITS = 2;

  localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

  // register indexes on the write port
  localparam logic [INDEX_BITS-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_DEST_BASE   = 2'd1;

  localparam logic [CHAR_BITS-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_Z = 8'h5A;
  localparam logic [DIGIT_BITS-1:0] TEN = 6'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LOAD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic step;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic [DIGIT_BITS-1:0] remainder;
  } div_status_t;

  function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
    logic [BASE_BITS-1:0] r;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    else r = b;
    return r;
  endfunction

  function automatic logic [DIGIT_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] diff;
    logic [DIGIT_BITS-1:0] r;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      r = diff[DIGIT_BITS-1:0];
    end else if (c >= CH_A && c <= CH_Z) begin
      diff = c - CH_A;
      r = diff[DIGIT_BITS-1:0] + TEN;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [CHAR_BITS-1:0] value_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] r;
    if (d >= TEN) r = CH_A + {2'b00, d - TEN};
    else r = CH_0 + {2'b00, d};
    return r;
  endfunction

endpackage

@@ design/rsc_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_mac
// Accumulator with multiply-add by the source base and sticky overflow.
// ----------------------------------------------------------------------------
module rsc_mac #(
  parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rsc_pkg::mac_ctrl_t              ctrl,
  input  logic [rsc_pkg::BASE_BITS-1:0]   base,
  input  logic [rsc_pkg::DIGIT_BITS-1:0]  digit,
  output logic [VALUE_BITS-1:0]           acc,
  output logic                            ovf
);

  localparam int PROD_BITS = VALUE_BITS + rsc_pkg::BASE_BITS;

  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS:0]   sum;

  assign prod = {{rsc_pkg::BASE_BITS{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, base};
  assign sum  = {1'b0, prod} + {{(PROD_BITS + 1 - rsc_pkg::DIGIT_BITS){1'b0}}, digit};

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
      ovf <= 1'b0;
    end else if (ctrl.step) begin
      acc <= sum[VALUE_BITS-1:0];
      // anything above the value width means the true value no longer fits
      ovf <= ovf | (|sum[PROD_BITS:VALUE_BITS]);
    end
  end

endmodule

@@ design/rsc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_div
// Restoring divider by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsc_div #(
  parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [rsc_pkg::BASE_BITS-1:0]  divisor,
  output logic [VALUE_BITS-1:0]          quotient,
  output rsc_pkg::div_status_t           status
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
  localparam int REM_BITS = rsc_pkg::DIGIT_BITS;

  logic [CNT_BITS-1:0]              cnt;
  logic                             running;
  logic                             done;
  logic [REM_BITS-1:0]              rem;
  logic [rsc_pkg::BASE_BITS-1:0]    dvsr;
  logic [REM_BITS:0]                trial;
  logic                             fits;
  logic [REM_BITS:0]                diff;

  assign trial = {rem, quotient[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNT_BITS'(VALUE_BITS);
    end else if (running) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_BITS'(1));
      if (cnt == CNT_BITS'(1)) running <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (running) begin
      quotient <= {quotient[VALUE_BITS-2:0], fits};
      // remainder stays below the divisor, so it fits in REM_BITS
      rem      <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
    end
  end

  assign status.done      = done;
  assign status.remainder = rem;

endmodule

@@ design/radix_string_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_converter
// Converts a digit string from one radix to another, one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive digit_char and last_char and raise start; the character is
//   taken at a clock edge where start is high and busy is low. Characters go
//   most significant first. Each character is accepted and then takes one
//   multiply-add in the accumulator.
//   Output: after the character that carries last_char, the value is split
//   into destination-base digits by a shared restoring divider, one digit per
//   divider pass, then played back most significant first.
//   Each digit shows on out_char/last_digit/overflow for one cycle while
//   strobe is high, after a read of the digit buffer. The receiver cannot
//   stall; each strobe is one transaction.
//   Configuration: wr_en/wr_index/wr_data write source_base (index 0) or
//   dest_base (index 1); other indexes are ignored. Out-of-range
//   bases are clamped to 2..36. Write only while busy is low.
//   Reset (rst, synchronous) returns both bases to 10, clears the
//   accumulator and the overflow flag and drops busy.
// ----------------------------------------------------------------------------
module radix_string_converter #(
  parameter int VALUE_BITS  = rsc_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_SLOTS = rsc_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rsc_pkg::CHAR_BITS-1:0]   digit_char,
  input  logic                            last_char,
  input  logic                            wr_en,
  input  logic [rsc_pkg::INDEX_BITS-1:0]  wr_index,
  input  logic [rsc_pkg::BASE_BITS-1:0]   wr_data,
  output logic                            strobe,
  output logic [rsc_pkg::CHAR_BITS-1:0]   out_char,
  output logic                            last_digit,
  output logic                            overflow
);

  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam int CW = $clog2(DIGIT_SLOTS + 1);

  rsc_pkg::state_t    state, state_next;
  rsc_pkg::mac_ctrl_t mac_ctrl;
  rsc_pkg::div_status_t div_status;

  logic [rsc_pkg::BASE_BITS-1:0]  source_base;
  logic [rsc_pkg::BASE_BITS-1:0]  dest_base;
  logic [rsc_pkg::DIGIT_BITS-1:0] digit_in;
  logic                           last_in;
  logic [VALUE_BITS-1:0]          acc;
  logic                           ovf;
  logic [VALUE_BITS-1:0]          value;
  logic [VALUE_BITS-1:0]          quotient;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_inc;
  logic [AW-1:0]                  ptr;
  logic                           div_go;
  logic                           mem_we;
  logic [rsc_pkg::DIGIT_BITS-1:0] digit_buffer [DIGIT_SLOTS];
  logic [rsc_pkg::DIGIT_BITS-1:0] rd_data;

  // configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= rsc_pkg::BASE_RESET;
      dest_base   <= rsc_pkg::BASE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        rsc_pkg::REG_SOURCE_BASE: source_base <= rsc_pkg::clamp_base(wr_data);
        rsc_pkg::REG_DEST_BASE:   dest_base   <= rsc_pkg::clamp_base(wr_data);
        default: ;
      endcase
    end
  end

  rsc_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mac_ctrl),
    .base  (source_base),
    .digit (digit_in),
    .acc   (acc),
    .ovf   (ovf)
  );

  rsc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (value),
    .divisor  (dest_base),
    .quotient (quotient),
    .status   (div_status)
  );

  assign count_inc = count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= rsc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next     = state;
    mac_ctrl.step  = 1'b0;
    mac_ctrl.clear = 1'b0;
    div_go         = 1'b0;
    mem_we         = 1'b0;
    unique case (state)
      rsc_pkg::S_IDLE: begin
        if (start) state_next = rsc_pkg::S_ACC;
      end
      rsc_pkg::S_ACC: begin
        mac_ctrl.step = 1'b1;
        state_next = last_in ? rsc_pkg::S_LOAD : rsc_pkg::S_IDLE;
      end
      rsc_pkg::S_LOAD: begin
        state_next = rsc_pkg::S_DIV_GO;
      end
      rsc_pkg::S_DIV_GO: begin
        div_go = 1'b1;
        state_next = rsc_pkg::S_DIV_WAIT;
      end
      rsc_pkg::S_DIV_WAIT: begin
        if (div_status.done) begin
          mem_we = 1'b1;
          // always at least one digit, so zero comes out as a single '0'
          if (quotient != '0 && count_inc < CW'(DIGIT_SLOTS))
            state_next = rsc_pkg::S_DIV_GO;
          else
            state_next = rsc_pkg::S_READ;
        end
      end
      rsc_pkg::S_READ: begin
        state_next = rsc_pkg::S_EMIT;
      end
      rsc_pkg::S_EMIT: begin
        if (ptr == '0) begin
          mac_ctrl.clear = 1'b1;
          state_next = rsc_pkg::S_IDLE;
        end else begin
          state_next = rsc_pkg::S_READ;
        end
      end
      default: state_next = rsc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rsc_pkg::S_IDLE && start) begin
      digit_in <= rsc_pkg::char_value(digit_char);
      last_in  <= last_char;
    end
    if (state == rsc_pkg::S_LOAD) begin
      value <= acc;
      count <= '0;
    end else if (mem_we) begin
      value <= quotient;
      count <= count_inc;
      ptr   <= count[AW-1:0];
    end else if (state == rsc_pkg::S_EMIT) begin
      ptr <= ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) digit_buffer[count[AW-1:0]] <= div_status.remainder;
    rd_data <= digit_buffer[ptr];
  end

  assign busy       = (state != rsc_pkg::S_IDLE);
  assign strobe     = (state == rsc_pkg::S_EMIT);
  assign out_char   = rsc_pkg::value_char(rd_data);
  assign last_digit = (ptr == '0);
  assign overflow   = ovf;

endmodule

@@ design/rsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks for the radix string converter, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last_digit
);

  // reset leaves the block idle and silent
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !strobe))
    else $error("busy or strobe right after reset");

  // an accepted character always occupies the block for its accumulate cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("character accepted but block not busy");

  // results only appear while a number is being emitted
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result transaction while idle");

  // each digit is read from the buffer before its strobe, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("back-to-back result transactions");

  // more digits follow until the final one is flagged
  a_more_digits: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_digit) |=> ##1 strobe)
    else $error("digit sequence ended without last_digit");

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .last_digit (last_digit)
);
